>>> sv/rk4ps_pkg.sv
package rk4ps_pkg;

	// Fixed widths of the item fields and the coefficient registers.
	localparam int DataW = 32;
	localparam int CfgIdxW = 2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CfgStepSize = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgCoefGravity = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgCoefSpring = 2'd2;

	localparam logic [DataW-1:0] StepSizeReset = 32'd429497;
	localparam logic [DataW-1:0] CoefGravityReset = 32'd9320676;
	localparam logic [DataW-1:0] CoefSpringReset = 32'd169869312;

	localparam int CordicIterDefault = 24;

	// Angle work register in Q2.30 with headroom for the wrapped input.
	localparam int ZW = 35;
	// CORDIC vector registers in Q2.30.
	localparam int XyW = 34;
	localparam logic signed [ZW-1:0] Q30Pi = 35'sd3373259426;
	localparam logic signed [ZW-1:0] Q30TwoPi = 35'sd6746518852;
	localparam logic signed [ZW-1:0] Q30HalfPi = 35'sd1686629713;
	localparam logic signed [XyW-1:0] Q30Gain = 34'sd652032874;
	localparam logic signed [XyW-1:0] Q30One = 34'sd1073741824;

	// Weighted sums and their magnitudes for the divide by six.
	localparam int KaW = 36;
	localparam int AccAW = 39;
	localparam int AccBW = 35;
	localparam int DivBits = 38;
	// Four shift-and-add refinements of the quotient and one remainder correction.
	localparam int DivSteps = 5;
	localparam int CntW = 6;
	localparam int SatW = 40;
	localparam int PcW = 4;

	typedef struct packed {
		logic op;
		logic signed [DataW-1:0] angle_in;
		logic signed [DataW-1:0] rate_in;
	} in_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] angle_out;
		logic signed [DataW-1:0] rate_out;
		logic saturated;
	} out_item_t;

	localparam logic OpLoad = 1'b0;
	localparam logic OpStep = 1'b1;

	typedef enum logic [3:0] {
		UOP_REDUCE,
		UOP_FOLD,
		UOP_CORDIC,
		UOP_TRIG,
		UOP_MUL_SC,
		UOP_SC,
		UOP_T1,
		UOP_DERIV,
		UOP_MUL_KB,
		UOP_KB,
		UOP_KA,
		UOP_ACCUM,
		UOP_DIV_INIT,
		UOP_DIV,
		UOP_FINISH,
		UOP_LOAD
	} uop_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_CORDIC,
		JMP_STAGE,
		JMP_DIV
	} jmp_t;

	typedef struct packed {
		uop_t op;
		jmp_t cond;
		logic [PcW-1:0] target;
	} ucw_t;

	localparam logic [PcW-1:0] PcStart = 4'd0;
	localparam logic [PcW-1:0] PcCordic = 4'd2;
	localparam logic [PcW-1:0] PcDiv = 4'd13;
	localparam logic [PcW-1:0] PcLoad = 4'd15;

	typedef struct packed {
		logic sat;
		logic signed [DataW-1:0] val;
	} sat_t;

	// Microprogram: one control word per step.
	function automatic ucw_t ucode(logic [PcW-1:0] pc);
		ucw_t w;
		w.cond = JMP_NONE;
		w.target = PcStart;
		case (pc)
			4'd0: w.op = UOP_REDUCE;
			4'd1: w.op = UOP_FOLD;
			4'd2: begin
				w.op = UOP_CORDIC;
				w.cond = JMP_CORDIC;
				w.target = PcCordic;
			end
			4'd3: w.op = UOP_TRIG;
			4'd4: w.op = UOP_MUL_SC;
			4'd5: w.op = UOP_SC;
			4'd6: w.op = UOP_T1;
			4'd7: w.op = UOP_DERIV;
			4'd8: w.op = UOP_MUL_KB;
			4'd9: w.op = UOP_KB;
			4'd10: w.op = UOP_KA;
			4'd11: begin
				w.op = UOP_ACCUM;
				w.cond = JMP_STAGE;
				w.target = PcStart;
			end
			4'd12: w.op = UOP_DIV_INIT;
			4'd13: begin
				w.op = UOP_DIV;
				w.cond = JMP_DIV;
				w.target = PcDiv;
			end
			4'd14: w.op = UOP_FINISH;
			default: w.op = UOP_LOAD;
		endcase
		return w;
	endfunction

	// Arctangent of 2^-i in Q2.30.
	function automatic logic [DataW-1:0] atan_q30(logic [4:0] i);
		logic [DataW-1:0] a;
		case (i)
			5'd0: a = 32'h3243F6A8;
			5'd1: a = 32'h1DAC6705;
			5'd2: a = 32'h0FADBAFC;
			5'd3: a = 32'h07F56EA6;
			5'd4: a = 32'h03FEAB76;
			5'd5: a = 32'h01FFD55B;
			5'd6: a = 32'h00FFFAAA;
			5'd7: a = 32'h007FFF55;
			5'd8: a = 32'h003FFFEA;
			5'd9: a = 32'h001FFFFD;
			5'd10: a = 32'h000FFFFF;
			5'd11: a = 32'h0007FFFF;
			5'd12: a = 32'h0003FFFF;
			5'd13: a = 32'h0001FFFF;
			5'd14: a = 32'h0000FFFF;
			5'd15: a = 32'h00007FFF;
			5'd16: a = 32'h00003FFF;
			5'd17: a = 32'h00001FFF;
			5'd18: a = 32'h00000FFF;
			5'd19: a = 32'h000007FF;
			5'd20: a = 32'h000003FF;
			5'd21: a = 32'h000001FF;
			5'd22: a = 32'h000000FF;
			5'd23: a = 32'h0000007F;
			5'd24: a = 32'h0000003F;
			5'd25: a = 32'h0000001F;
			5'd26: a = 32'h0000000F;
			5'd27: a = 32'h00000007;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// Saturate a wide signed value to 32 bits and report the clip.
	function automatic sat_t sat32(logic signed [SatW-1:0] v);
		sat_t r;
		if (v > SatW'(32'sh7FFFFFFF)) begin
			r.sat = 1'b1;
			r.val = 32'sh7FFFFFFF;
		end else if (v < -SatW'(41'sd2147483648)) begin
			r.sat = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.sat = 1'b0;
			r.val = v[DataW-1:0];
		end
		return r;
	endfunction

	// Limit a CORDIC output to [-1, 1] in Q2.30.
	function automatic logic signed [DataW-1:0] clamp_unit(logic signed [XyW-1:0] v);
		logic signed [XyW-1:0] r;
		if (v > Q30One) begin
			r = Q30One;
		end else if (v < -Q30One) begin
			r = -Q30One;
		end else begin
			r = v;
		end
		return r[DataW-1:0];
	endfunction

endpackage

>>> sv/rk4_pendulum_step_unit.sv
// One fourth-order Runge-Kutta step of a pendulum with a spring term, in fixed
// point. An input transaction with op 0 loads angle (Q4.28) and rate (Q8.24);
// with op 1 it advances the state by one step of size step_size. Every input
// transaction yields exactly one output transaction carrying the new state and
// a flag that is set when any derivative, evaluation point or final value was
// clipped. Work runs on a microcoded sequencer driving one shared 33x33
// multiplier, one CORDIC iteration per cycle and a shift-and-add divide by six.
// A step runs its four CORDIC evaluations one after another. The block holds one
// item at a time: in_ready is low from acceptance until the result enters the
// output register, which lets a finished result wait for out_ready while the
// next item is accepted. Configuration writes are always accepted and must only
// be issued while the block is idle.
module rk4_pendulum_step_unit
	import rk4ps_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = CordicIterDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [DataW-1:0]     cfg_data
);

	// Configuration and architectural state.
	logic [DataW-1:0] step_size_q, coef_gravity_q, coef_spring_q;
	logic signed [DataW-1:0] angle_q, rate_q;

	// Sequencer control.
	logic busy_q;
	logic [PcW-1:0] pc_q;
	logic [CntW-1:0] cnt_q;
	logic [1:0] k_q;
	logic flag_q;
	logic out_valid_q;
	out_item_t out_q;

	// Datapath registers.
	logic signed [DataW-1:0] th_q, w_q;
	logic signed [ZW-1:0] z_q;
	logic signed [XyW-1:0] x_q, y_q;
	logic neg_q;
	logic signed [DataW-1:0] s_q, c_q, sc_q, d_q, kb_q;
	logic signed [ZW-1:0] t_q;
	logic signed [65:0] prod_q;
	logic signed [KaW-1:0] ka_q;
	logic signed [AccAW-1:0] acc_a_q;
	logic signed [AccBW-1:0] acc_b_q;
	logic [DivBits-1:0] qa_q, qb_q, ma_q, mb_q;
	logic sign_a_q, sign_b_q;

	ucw_t uw;
	logic jump;
	logic slot_free;
	logic accept;
	logic done;

	// Shared multiplier operands.
	logic signed [32:0] mul_a, mul_b;

	// Per-step combinational results.
	logic signed [ZW-1:0] z_wrap, z_fold, at_ext;
	logic fold_neg;
	logic signed [XyW-1:0] x_sh, y_sh, x_fin, y_fin;
	logic signed [ZW:0] deriv_sum;
	sat_t deriv_sat, pt_a_sat, pt_b_sat, fin_a_sat, fin_b_sat;
	logic signed [KaW-1:0] step_a;
	logic signed [DataW-1:0] step_b;
	logic dbl;
	logic signed [AccAW-1:0] abs_a;
	logic signed [AccBW-1:0] abs_b;
	logic [5:0] shamt;
	logic [5:0] ra, rb;
	logic [DivBits-1:0] fix_a, fix_b;
	logic signed [AccAW-1:0] sa, sb;

	assign accept = in_valid && in_ready;
	assign in_ready = !busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign slot_free = !out_valid_q || out_ready;
	// The last micro-operation of an item moves its result into the output register.
	assign done = busy_q && (uw.op == UOP_FINISH || uw.op == UOP_LOAD) && slot_free;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.cond)
			JMP_CORDIC: jump = (cnt_q != CntW'(CORDIC_ITERATIONS - 1));
			JMP_STAGE: jump = (k_q != 2'd3);
			JMP_DIV: jump = (cnt_q != CntW'(DivSteps - 1));
			default: jump = 1'b0;
		endcase
	end

	// Multiplier operand selection by micro-operation.
	always_comb begin
		case (uw.op)
			UOP_MUL_SC: begin
				mul_a = 33'(s_q);
				mul_b = 33'(c_q);
			end
			UOP_SC: begin
				mul_a = $signed({1'b0, coef_gravity_q});
				mul_b = 33'(s_q);
			end
			UOP_T1: begin
				mul_a = $signed({1'b0, coef_spring_q});
				mul_b = 33'(sc_q);
			end
			UOP_MUL_KB: begin
				mul_a = $signed({1'b0, step_size_q});
				mul_b = 33'(d_q);
			end
			default: begin
				mul_a = $signed({1'b0, step_size_q});
				mul_b = 33'(w_q);
			end
		endcase
	end

	always_comb begin
		// Angle into Q2.30 and one wrap into [-pi, pi].
		z_wrap = $signed({th_q[DataW-1], th_q, 2'b00});
		if (z_wrap > Q30Pi) begin
			z_wrap = z_wrap - Q30TwoPi;
		end else if (z_wrap < -Q30Pi) begin
			z_wrap = z_wrap + Q30TwoPi;
		end
		// Fold into [-pi/2, pi/2]; the folded half negates sin and cos.
		fold_neg = 1'b0;
		z_fold = z_q;
		if (z_q > Q30HalfPi) begin
			z_fold = z_q - Q30Pi;
			fold_neg = 1'b1;
		end else if (z_q < -Q30HalfPi) begin
			z_fold = z_q + Q30Pi;
			fold_neg = 1'b1;
		end

		x_sh = x_q >>> cnt_q[4:0];
		y_sh = y_q >>> cnt_q[4:0];
		at_ext = ZW'(atan_q30(cnt_q[4:0]));
		x_fin = neg_q ? -x_q : x_q;
		y_fin = neg_q ? -y_q : y_q;

		deriv_sum = (ZW+1)'(t_q) + (ZW+1)'(prod_q >>> 30);
		deriv_sat = sat32(SatW'(-deriv_sum));

		dbl = (k_q == 2'd1) || (k_q == 2'd2);
		step_a = (k_q == 2'd2) ? ka_q : (ka_q >>> 1);
		step_b = (k_q == 2'd2) ? kb_q : (kb_q >>> 1);
		pt_a_sat = sat32(SatW'(angle_q) + SatW'(step_a));
		pt_b_sat = sat32(SatW'(rate_q) + SatW'(step_b));

		abs_a = acc_a_q[AccAW-1] ? -acc_a_q : acc_a_q;
		abs_b = acc_b_q[AccBW-1] ? -acc_b_q : acc_b_q;

		// Divide by six as a halving followed by a divide by three. The quotient
		// starts at m * 5/16 and each pass multiplies it by 1 + 2^-4, 2^-8, 2^-16
		// and 2^-32, which approaches m / 3 from below. The remainder left after
		// that is under 32, so its low six bits are exact and 11r/32 rounds it
		// down to the missing quotient.
		case (cnt_q[1:0])
			2'd0: shamt = 6'd4;
			2'd1: shamt = 6'd8;
			2'd2: shamt = 6'd16;
			default: shamt = 6'd32;
		endcase
		ra = ma_q[5:0] - ((qa_q[5:0] << 1) + qa_q[5:0]);
		rb = mb_q[5:0] - ((qb_q[5:0] << 1) + qb_q[5:0]);
		fix_a = DivBits'(({4'd0, ra} * 10'd11) >> 5);
		fix_b = DivBits'(({4'd0, rb} * 10'd11) >> 5);

		sa = sign_a_q ? -$signed({1'b0, qa_q}) : $signed({1'b0, qa_q});
		sb = sign_b_q ? -$signed({1'b0, qb_q}) : $signed({1'b0, qb_q});
		fin_a_sat = sat32(SatW'(angle_q) + SatW'(sa));
		fin_b_sat = sat32(SatW'(rate_q) + SatW'(sb));
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= PcStart;
			out_valid_q <= 1'b0;
			step_size_q <= StepSizeReset;
			coef_gravity_q <= CoefGravityReset;
			coef_spring_q <= CoefSpringReset;
			angle_q <= '0;
			rate_q <= '0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgStepSize: step_size_q <= cfg_data;
					CfgCoefGravity: coef_gravity_q <= cfg_data;
					CfgCoefSpring: coef_spring_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				busy_q <= 1'b1;
				pc_q <= (in_data.op == OpLoad) ? PcLoad : PcStart;
			end else if (busy_q) begin
				if (uw.op == UOP_FINISH || uw.op == UOP_LOAD) begin
					if (slot_free) begin
						busy_q <= 1'b0;
						if (uw.op == UOP_FINISH) begin
							angle_q <= fin_a_sat.val;
							rate_q <= fin_b_sat.val;
						end else begin
							angle_q <= th_q;
							rate_q <= w_q;
						end
					end
				end else begin
					pc_q <= jump ? uw.target : pc_q + PcW'(1);
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			th_q <= (in_data.op == OpLoad) ? in_data.angle_in : angle_q;
			w_q <= (in_data.op == OpLoad) ? in_data.rate_in : rate_q;
			k_q <= 2'd0;
			flag_q <= 1'b0;
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (busy_q) begin
			case (uw.op)
				UOP_REDUCE: z_q <= z_wrap;
				UOP_FOLD: begin
					z_q <= z_fold;
					neg_q <= fold_neg;
					x_q <= Q30Gain;
					y_q <= '0;
					cnt_q <= '0;
				end
				UOP_CORDIC: begin
					if (!z_q[ZW-1]) begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						z_q <= z_q - at_ext;
					end else begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						z_q <= z_q + at_ext;
					end
					cnt_q <= cnt_q + CntW'(1);
				end
				UOP_TRIG: begin
					s_q <= clamp_unit(y_fin);
					c_q <= clamp_unit(x_fin);
				end
				UOP_MUL_SC: prod_q <= mul_a * mul_b;
				UOP_SC: begin
					sc_q <= DataW'(prod_q >>> 30);
					prod_q <= mul_a * mul_b;
				end
				UOP_T1: begin
					t_q <= ZW'(prod_q >>> 30);
					prod_q <= mul_a * mul_b;
				end
				UOP_DERIV: begin
					d_q <= deriv_sat.val;
					flag_q <= flag_q | deriv_sat.sat;
				end
				UOP_MUL_KB: prod_q <= mul_a * mul_b;
				UOP_KB: begin
					kb_q <= DataW'(prod_q >>> 32);
					prod_q <= mul_a * mul_b;
				end
				UOP_KA: ka_q <= KaW'(prod_q >>> 28);
				UOP_ACCUM: begin
					acc_a_q <= acc_a_q + (dbl ? (AccAW'(ka_q) <<< 1) : AccAW'(ka_q));
					acc_b_q <= acc_b_q + (dbl ? (AccBW'(kb_q) <<< 1) : AccBW'(kb_q));
					if (k_q != 2'd3) begin
						th_q <= pt_a_sat.val;
						w_q <= pt_b_sat.val;
						flag_q <= flag_q | pt_a_sat.sat | pt_b_sat.sat;
						k_q <= k_q + 2'd1;
					end
				end
				UOP_DIV_INIT: begin
					ma_q <= DivBits'(abs_a >> 1);
					mb_q <= DivBits'(abs_b >> 1);
					qa_q <= DivBits'(abs_a >> 3) + DivBits'(abs_a >> 5);
					qb_q <= DivBits'(abs_b >> 3) + DivBits'(abs_b >> 5);
					sign_a_q <= acc_a_q[AccAW-1];
					sign_b_q <= acc_b_q[AccBW-1];
					cnt_q <= '0;
				end
				UOP_DIV: begin
					if (cnt_q == CntW'(DivSteps - 1)) begin
						qa_q <= qa_q + fix_a;
						qb_q <= qb_q + fix_b;
					end else begin
						qa_q <= qa_q + (qa_q >> shamt);
						qb_q <= qb_q + (qb_q >> shamt);
					end
					cnt_q <= cnt_q + CntW'(1);
				end
				UOP_FINISH: begin
					if (slot_free) begin
						out_q.angle_out <= fin_a_sat.val;
						out_q.rate_out <= fin_b_sat.val;
						out_q.saturated <= flag_q | fin_a_sat.sat | fin_b_sat.sat;
					end
				end
				default: begin
					if (slot_free) begin
						out_q.angle_out <= th_q;
						out_q.rate_out <= w_q;
						out_q.saturated <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

>>> sv/rk4ps_checker.sv
module rk4ps_checker
	import rk4ps_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input in_item_t             in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input out_item_t            out_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CfgIdxW-1:0]   cfg_index,
	input logic [DataW-1:0]     cfg_data
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// A load into an empty output register echoes the loaded state unclipped.
	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == OpLoad && !out_valid |=> ##1
		out_valid && out_data.angle_out == $past(in_data.angle_in, 2)
		&& out_data.rate_out == $past(in_data.rate_in, 2) && !out_data.saturated)
		else $error("load result does not match loaded state");

endmodule

bind rk4_pendulum_step_unit rk4ps_checker u_rk4ps_checker (.*);
